// File: rtl/kvt_pkg.sv
// kvt_pkg: shared constants, command codes and types for the key/value table.
// No dependencies; compiled first.
`default_nettype none

package kvt_pkg;

  // Fixed field widths
  localparam int CMD_W   = 3;
  localparam int INDEX_W = 4;
  localparam int FILL_W  = 5;
  localparam int CAP_W   = 5;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UPSERT     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOOKUP     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ_INDEX = 3'd5;

  // Port strobes from the sequencer to the pair memory
  typedef struct packed {
    logic rd_en;   // registered read of key and value
    logic wr_key;  // write key entry
    logic wr_val;  // write value entry
  } mem_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/kvt_ifs.sv
// kvt_ifs: valid/ready channel interfaces for requests, results and capacity writes.
// Depends on kvt_pkg.
`default_nettype none

interface kvt_cmd_if import kvt_pkg::*; #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) ();
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      command;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;
  logic [INDEX_W-1:0]    index;

  modport source(output valid, command, key, value, index, input ready);
  modport sink(input valid, command, key, value, index, output ready);
endinterface

interface kvt_rsp_if import kvt_pkg::*; #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) ();
  logic                  valid;
  logic                  ready;
  logic                  ok;
  logic [KEY_BITS-1:0]   key_out;
  logic [VALUE_BITS-1:0] value_out;
  logic [FILL_W-1:0]     fill_count;
  logic                  is_empty;

  modport source(output valid, ok, key_out, value_out, fill_count, is_empty, input ready);
  modport sink(input valid, ok, key_out, value_out, fill_count, is_empty, output ready);
endinterface

interface kvt_cfg_if import kvt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

`default_nettype wire

// File: rtl/kvt_store.sv
// kvt_store: pair memory, one write port per array and one registered read port.
// Depends on kvt_pkg.
`default_nettype none

module kvt_store import kvt_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire mem_ctrl_t             ctrl,
  input  wire logic [AW-1:0]         rd_addr,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire logic [KEY_BITS-1:0]   wr_key_data,
  input  wire logic [VALUE_BITS-1:0] wr_val_data,
  output      logic [KEY_BITS-1:0]   rd_key,
  output      logic [VALUE_BITS-1:0] rd_val
);

  logic [KEY_BITS-1:0]   key_mem [DEPTH];
  logic [VALUE_BITS-1:0] val_mem [DEPTH];

  // Writes
  always_ff @(posedge clk) begin
    if (ctrl.wr_key) begin
      key_mem[wr_addr] <= wr_key_data;
    end
    if (ctrl.wr_val) begin
      val_mem[wr_addr] <= wr_val_data;
    end
  end

  // Registered read; data holds until the next read strobe
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_val <= val_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/kvt_seq.sv
// kvt_seq: command sequencer with the shared key comparator, fill count and result register.
// Depends on kvt_pkg and kvt_ifs; drives the kvt_store ports.
`default_nettype none

module kvt_seq import kvt_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  kvt_cmd_if.sink                    cmd,
  kvt_rsp_if.source                  rsp,
  input  wire logic [CAP_W-1:0]      capacity,
  output      mem_ctrl_t             mem_ctrl,
  output      logic [AW-1:0]         rd_addr,
  output      logic [AW-1:0]         wr_addr,
  output      logic [KEY_BITS-1:0]   wr_key_data,
  output      logic [VALUE_BITS-1:0] wr_val_data,
  input  wire logic [KEY_BITS-1:0]   rd_key,
  input  wire logic [VALUE_BITS-1:0] rd_val
);

  // Compare widths wide enough for both operands
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;
  localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_SEARCH     = 3'd1;
  localparam logic [2:0] S_ERASE_RD   = 3'd2;
  localparam logic [2:0] S_ERASE_WR   = 3'd3;
  localparam logic [2:0] S_INDEX_RD   = 3'd4;
  localparam logic [2:0] S_INDEX_WAIT = 3'd5;
  localparam logic [2:0] S_FINISH     = 3'd6;

  logic [2:0]            state;
  logic [CMD_W-1:0]      cmd_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [INDEX_W-1:0]    idx_r;
  logic [CW-1:0]         count;
  logic [CW-1:0]         ptr;
  logic                  pend;      // a read of entry hit_addr is in rd_key/rd_val
  logic [AW-1:0]         hit_addr;
  logic                  res_ok;
  logic [KEY_BITS-1:0]   res_key;
  logic [VALUE_BITS-1:0] res_val;

  logic match;
  logic scan_end;
  logic has_room;
  logic idx_ok;
  logic appends;

  // Shared comparator and bounds checks
  assign match    = pend && (rd_key == key_r);
  assign scan_end = (ptr >= count);
  assign has_room = (EW'(count) < EW'(capacity)) && (count < CW'(DEPTH));
  assign idx_ok   = (XW'(idx_r) < XW'(count));
  assign appends  = ((cmd_r == CMD_INSERT) || (cmd_r == CMD_UPSERT)) && has_room;

  assign cmd.ready = (state == S_IDLE);

  // Memory port control
  always_comb begin
    mem_ctrl    = '0;
    rd_addr     = AW'(ptr);
    wr_addr     = hit_addr;
    wr_key_data = key_r;
    wr_val_data = val_r;
    unique case (state)
      S_SEARCH: begin
        if (match) begin
          mem_ctrl.wr_val = (cmd_r == CMD_UPDATE) || (cmd_r == CMD_UPSERT);
        end else if (scan_end) begin
          mem_ctrl.wr_key = appends;
          mem_ctrl.wr_val = appends;
          wr_addr         = AW'(count);
        end else begin
          mem_ctrl.rd_en = 1'b1;
        end
      end
      S_ERASE_RD: begin
        mem_ctrl.rd_en = 1'b1;
        rd_addr        = AW'(count - 1'b1);
      end
      S_ERASE_WR: begin
        mem_ctrl.wr_key = 1'b1;
        mem_ctrl.wr_val = 1'b1;
        wr_key_data     = rd_key;
        wr_val_data     = rd_val;
      end
      S_INDEX_RD: begin
        mem_ctrl.rd_en = idx_ok;
        rd_addr        = AW'(idx_r);
      end
      default: begin
      end
    endcase
  end

  // Sequencer, fill count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      // the finish state reloads the result register itself
      if (rsp.valid && rsp.ready && (state != S_FINISH)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            cmd_r   <= cmd.command;
            key_r   <= cmd.key;
            val_r   <= cmd.value;
            idx_r   <= cmd.index;
            ptr     <= '0;
            pend    <= 1'b0;
            res_ok  <= 1'b0;
            res_key <= '0;
            res_val <= '0;
            case (cmd.command) inside
              CMD_INSERT, CMD_UPDATE, CMD_UPSERT, CMD_ERASE, CMD_LOOKUP: state <= S_SEARCH;
              CMD_READ_INDEX: state <= S_INDEX_RD;
              default:        state <= S_FINISH;
            endcase
          end
        end
        S_SEARCH: begin
          if (match) begin
            pend <= 1'b0;
            case (cmd_r) inside
              CMD_UPDATE, CMD_UPSERT: begin
                res_ok <= 1'b1;
                state  <= S_FINISH;
              end
              CMD_ERASE: state <= S_ERASE_RD;
              CMD_LOOKUP: begin
                res_ok  <= 1'b1;
                res_val <= rd_val;
                state   <= S_FINISH;
              end
              default: state <= S_FINISH;
            endcase
          end else if (scan_end) begin
            pend <= 1'b0;
            if (appends) begin
              count  <= count + 1'b1;
              res_ok <= 1'b1;
            end
            state <= S_FINISH;
          end else begin
            // one stored key per cycle into the comparator
            pend     <= 1'b1;
            hit_addr <= AW'(ptr);
            ptr      <= ptr + 1'b1;
          end
        end
        S_ERASE_RD: state <= S_ERASE_WR;
        S_ERASE_WR: begin
          count  <= count - 1'b1;
          res_ok <= 1'b1;
          state  <= S_FINISH;
        end
        S_INDEX_RD: state <= idx_ok ? S_INDEX_WAIT : S_FINISH;
        S_INDEX_WAIT: begin
          res_ok  <= 1'b1;
          res_key <= rd_key;
          res_val <= rd_val;
          state   <= S_FINISH;
        end
        S_FINISH: begin
          // hand over once the result register is free
          if (!rsp.valid || rsp.ready) begin
            rsp.valid      <= 1'b1;
            rsp.ok         <= res_ok;
            rsp.key_out    <= res_key;
            rsp.value_out  <= res_val;
            rsp.fill_count <= FILL_W'(count);
            rsp.is_empty   <= (count == '0);
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/key_value_table.sv
// Key/value table: up to DEPTH unique key/value pairs kept packed at positions
// 0 .. fill_count-1. A request is taken only while the block is idle; insert, update,
// insert-or-update, erase and lookup scan the stored keys through the single read port
// of the pair memory, one key per cycle against one shared comparator, and the scan
// stops at the first matching key or at the fill count. An erase that finds its key
// moves the last pair into the hole. Read-by-index reads the pair at the index, skipping
// the read when the index is at or past the fill count; an undefined command goes
// straight to the result. The result sits in an output register, so the next request
// may be taken while it waits. The capacity register (reset 16, clipped to DEPTH) may be
// written at any time the block is idle; the write channel is always ready.
// Depends on kvt_pkg, kvt_ifs, kvt_store and kvt_seq.
`default_nettype none

module key_value_table import kvt_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  kvt_cmd_if.sink   cmd,
  kvt_rsp_if.source rsp,
  kvt_cfg_if.sink   cfg
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CAP_W-1:0]      capacity;
  mem_ctrl_t             mem_ctrl;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [KEY_BITS-1:0]   wr_key_data;
  logic [VALUE_BITS-1:0] wr_val_data;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;

  // Capacity register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg.valid) begin
      capacity <= cfg.data;
    end
  end

  kvt_seq #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rsp         (rsp),
    .capacity    (capacity),
    .mem_ctrl    (mem_ctrl),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .wr_key_data (wr_key_data),
    .wr_val_data (wr_val_data),
    .rd_key      (rd_key),
    .rd_val      (rd_val)
  );

  kvt_store #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk         (clk),
    .ctrl        (mem_ctrl),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .wr_key_data (wr_key_data),
    .wr_val_data (wr_val_data),
    .rd_key      (rd_key),
    .rd_val      (rd_val)
  );

endmodule

`default_nettype wire

// File: rtl/kvt_checker.sv
// kvt_checker: port-level assertions for key_value_table, attached by bind.
// Depends on kvt_pkg and key_value_table.
`default_nettype none

module kvt_checker import kvt_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  cmd_valid,
  input wire logic                  cmd_ready,
  input wire logic                  rsp_valid,
  input wire logic                  rsp_ready,
  input wire logic                  ok,
  input wire logic [KEY_BITS-1:0]   key_out,
  input wire logic [VALUE_BITS-1:0] value_out,
  input wire logic [FILL_W-1:0]     fill_count,
  input wire logic                  is_empty
);

  // A stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(ok) && $stable(key_out) && $stable(value_out)
                                && $stable(fill_count) && $stable(is_empty))
    else $error("result payload changed while stalled");

  // The block is busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("request taken while previous one still in progress");

  // Empty flag agrees with the fill count (checked only for DEPTH up to 31)
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (DEPTH > 31) || (is_empty == (fill_count == '0)))
    else $error("empty flag disagrees with fill count");

endmodule

bind key_value_table kvt_checker #(
  .DEPTH      (DEPTH),
  .KEY_BITS   (KEY_BITS),
  .VALUE_BITS (VALUE_BITS)
) u_kvt_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .ok         (rsp.ok),
  .key_out    (rsp.key_out),
  .value_out  (rsp.value_out),
  .fill_count (rsp.fill_count),
  .is_empty   (rsp.is_empty)
);

`default_nettype wire

// File: tb/key_value_table_tb.sv
`timescale 1ns / 100ps
// key_value_table_tb: self-checking bench for the key/value table; a shadow copy of the
// pair table predicts every reply. Depends on kvt_pkg, kvt_ifs and key_value_table.

module key_value_table_tb;
  import kvt_pkg::*;

  localparam int TABLE_DEPTH      = 16;
  localparam int KEY_BITS         = 32;
  localparam int VALUE_BITS       = 32;
  localparam int SETTLE_CYCLES    = TABLE_DEPTH + 8;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PHASES           = 8;
  localparam int PHASE_ITEMS      = 200;
  localparam int POOL_SIZE        = 24;
  localparam int MAX_REPORTS      = 10;

  // Undefined command codes; the block answers them as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]      command;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [INDEX_W-1:0]    index;
  } kv_request_t;

  typedef struct packed {
    logic                  ok;
    logic [KEY_BITS-1:0]   key_out;
    logic [VALUE_BITS-1:0] value_out;
    logic [FILL_W-1:0]     fill_count;
    logic                  is_empty;
  } kv_reply_t;

  // Shadow pair table: predicts each reply and checks replies in order
  class pair_table_shadow;
    logic [KEY_BITS-1:0]   keys [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] vals [TABLE_DEPTH];
    int unsigned pairs;
    int unsigned capacity;
    kv_reply_t   awaited [$];
    int unsigned mismatches;
    int unsigned strays;
    int unsigned replies_checked;
    int unsigned hits;
    int unsigned full_refusals;

    function new();
      pairs           = 0;
      capacity        = CAP_RESET;
      mismatches      = 0;
      strays          = 0;
      replies_checked = 0;
      hits            = 0;
      full_refusals   = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      capacity = c;
    endfunction

    // Capacity above the table size counts as the table size
    function int unsigned slot_limit();
      return (capacity > TABLE_DEPTH) ? TABLE_DEPTH : capacity;
    endfunction

    // Position of k among stored pairs, pairs when absent
    function int unsigned find_slot(logic [KEY_BITS-1:0] k);
      for (int unsigned i = 0; i < pairs; i++) begin
        if (keys[i] == k) return i;
      end
      return pairs;
    endfunction

    function bit append(logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
      if (pairs >= slot_limit()) begin
        full_refusals++;
        return 1'b0;
      end
      keys[pairs] = k;
      vals[pairs] = v;
      pairs++;
      return 1'b1;
    endfunction

    function void apply_request(kv_request_t r);
      kv_reply_t   rep;
      int unsigned pos;
      rep = '0;
      pos = find_slot(r.key);
      case (r.command)
        CMD_INSERT: begin
          if (pos == pairs) rep.ok = append(r.key, r.value);
        end
        CMD_UPDATE: begin
          if (pos < pairs) begin
            vals[pos] = r.value;
            rep.ok    = 1'b1;
          end
        end
        CMD_UPSERT: begin
          if (pos < pairs) begin
            vals[pos] = r.value;
            rep.ok    = 1'b1;
          end else begin
            rep.ok = append(r.key, r.value);
          end
        end
        CMD_ERASE: begin
          // last pair fills the hole
          if (pos < pairs) begin
            keys[pos] = keys[pairs-1];
            vals[pos] = vals[pairs-1];
            pairs--;
            rep.ok = 1'b1;
          end
        end
        CMD_LOOKUP: begin
          if (pos < pairs) begin
            rep.value_out = vals[pos];
            rep.ok        = 1'b1;
          end
        end
        CMD_READ_INDEX: begin
          if (r.index < pairs) begin
            rep.key_out   = keys[r.index];
            rep.value_out = vals[r.index];
            rep.ok        = 1'b1;
          end
        end
        default: begin
        end
      endcase
      rep.fill_count = FILL_W'(pairs);
      rep.is_empty   = (pairs == 0);
      if (rep.ok) hits++;
      awaited.push_back(rep);
    endfunction

    function void compare_result(kv_reply_t got);
      kv_reply_t want;
      replies_checked++;
      if (awaited.size() == 0) begin
        strays++;
        if (mismatches + strays <= MAX_REPORTS)
          $display("ERROR %0t: reply with nothing awaited: ok=%0b key=%h val=%h fill=%0d empty=%0b",
                   $time, got.ok, got.key_out, got.value_out, got.fill_count, got.is_empty);
        return;
      end
      want = awaited.pop_front();
      if (got.ok !== want.ok || got.key_out !== want.key_out ||
          got.value_out !== want.value_out || got.fill_count !== want.fill_count ||
          got.is_empty !== want.is_empty) begin
        mismatches++;
        if (mismatches + strays <= MAX_REPORTS) begin
          $display("ERROR %0t: reply %0d: expected ok=%0b key=%h val=%h fill=%0d empty=%0b",
                   $time, replies_checked, want.ok, want.key_out, want.value_out,
                   want.fill_count, want.is_empty);
          $display("               got      ok=%0b key=%h val=%h fill=%0d empty=%0b",
                   got.ok, got.key_out, got.value_out, got.fill_count, got.is_empty);
        end
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function int unsigned failures();
      return mismatches + strays + awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  kvt_cmd_if #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) cmd_bus ();
  kvt_rsp_if #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) rsp_bus ();
  kvt_cfg_if cfg_bus ();

  key_value_table #(
    .DEPTH      (TABLE_DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  pair_table_shadow table_shadow = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_asked;
  int unsigned hold_served;
  int unsigned requests_sent;
  int unsigned cap_writes;
  int unsigned cmd_counts [8];
  logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("TIMEOUT: run did not finish, %0d replies still awaited", table_shadow.pending());
    $display("Test completed with failures");
    $finish;
  end

  // Reply side: check accepted replies, drive ready with random stalls and long holds
  initial begin : reply_sink
    int        hold_left;
    kv_reply_t got;
    hold_left     = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
        got.ok         = rsp_bus.ok;
        got.key_out    = rsp_bus.key_out;
        got.value_out  = rsp_bus.value_out;
        got.fill_count = rsp_bus.fill_count;
        got.is_empty   = rsp_bus.is_empty;
        table_shadow.compare_result(got);
      end
      if (hold_served < hold_asked) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // One request: random idle gap, then hold valid until accepted
  task automatic send_request(input logic [CMD_W-1:0] c, input logic [KEY_BITS-1:0] k,
                              input logic [VALUE_BITS-1:0] v, input logic [INDEX_W-1:0] i);
    kv_request_t r;
    r.command = c;
    r.key     = k;
    r.value   = v;
    r.index   = i;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid   <= 1'b1;
    cmd_bus.command <= c;
    cmd_bus.key     <= k;
    cmd_bus.value   <= v;
    cmd_bus.index   <= i;
    do @(posedge clk); while (cmd_bus.ready !== 1'b1);
    table_shadow.apply_request(r);
    requests_sent++;
    cmd_counts[c]++;
  endtask

  // Stop offering requests until every awaited reply is in
  task automatic drain_replies();
    cmd_bus.valid <= 1'b0;
    while (table_shadow.pending() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= c;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    table_shadow.set_capacity(c);
    cap_writes++;
  endtask

  // Mostly keys from a small pool so hits, duplicates and full tables are common
  task automatic send_random_request();
    logic [CMD_W-1:0]    c;
    logic [KEY_BITS-1:0] k;
    int unsigned         roll;
    roll = $urandom_range(99);
    if (roll < 20)      c = CMD_INSERT;
    else if (roll < 32) c = CMD_UPDATE;
    else if (roll < 50) c = CMD_UPSERT;
    else if (roll < 68) c = CMD_ERASE;
    else if (roll < 84) c = CMD_LOOKUP;
    else if (roll < 97) c = CMD_READ_INDEX;
    else                c = $urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7;
    if ($urandom_range(99) < 85) k = key_pool[$urandom_range(POOL_SIZE-1)];
    else                         k = $urandom();
    send_request(c, k, $urandom(), INDEX_W'($urandom_range(TABLE_DEPTH-1)));
  endtask

  // Replace a few pool keys so stale pairs linger and new ones arrive
  task automatic refresh_pool(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      key_pool[$urandom_range(POOL_SIZE-1)] = $urandom();
    end
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] cap_plan [PHASES];
    cap_plan = '{5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'd2, 5'd16, 5'd12};
    rst             = 1'b1;
    cmd_bus.valid   = 1'b0;
    cmd_bus.command = CMD_INSERT;
    cmd_bus.key     = '0;
    cmd_bus.value   = '0;
    cmd_bus.index   = '0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.data    = CAP_RESET;
    send_idle_pct   = 31;
    recv_idle_pct   = 76;
    hold_asked      = 0;
    hold_served     = 0;
    requests_sent   = 0;
    cap_writes      = 0;
    foreach (cmd_counts[n]) cmd_counts[n] = 0;
    for (int n = 0; n < POOL_SIZE; n++) key_pool[n] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, undefined codes, extreme keys and values, erase into a hole
    send_request(CMD_LOOKUP,     32'h0000_0000, 32'h0000_0000, 4'd0);
    send_request(CMD_READ_INDEX, 32'h0000_0000, 32'h0000_0000, 4'd0);
    send_request(CMD_ERASE,      32'h0000_0000, 32'h0000_0000, 4'd0);
    send_request(CMD_UPDATE,     32'h0000_0000, 32'hFFFF_FFFF, 4'd0);
    send_request(CMD_SPARE_6,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    send_request(CMD_SPARE_7,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    send_request(CMD_INSERT,     32'h0000_0000, 32'h0000_0000, 4'd0);
    send_request(CMD_INSERT,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    send_request(CMD_INSERT,     32'h0000_0000, 32'h0000_0001, 4'd0);
    send_request(CMD_UPDATE,     32'h0000_0000, 32'hA5A5_A5A5, 4'd0);
    send_request(CMD_UPSERT,     32'hFFFF_FFFF, 32'h5A5A_5A5A, 4'd0);
    send_request(CMD_UPSERT,     32'h1234_5678, 32'h0F0F_0F0F, 4'd0);
    send_request(CMD_LOOKUP,     32'h0000_0000, 32'h0000_0000, 4'd0);
    send_request(CMD_LOOKUP,     32'hFFFF_FFFF, 32'h0000_0000, 4'd0);
    send_request(CMD_LOOKUP,     32'h1357_9BDF, 32'h0000_0000, 4'd0);
    send_request(CMD_READ_INDEX, 32'h0000_0000, 32'h0000_0000, 4'd0);
    send_request(CMD_READ_INDEX, 32'h0000_0000, 32'h0000_0000, 4'd2);
    send_request(CMD_READ_INDEX, 32'h0000_0000, 32'h0000_0000, 4'd3);
    send_request(CMD_READ_INDEX, 32'h0000_0000, 32'h0000_0000, 4'd15);
    send_request(CMD_ERASE,      32'h0000_0000, 32'h0000_0000, 4'd0);
    send_request(CMD_READ_INDEX, 32'h0000_0000, 32'h0000_0000, 4'd0);
    send_request(CMD_ERASE,      32'h1234_5678, 32'h0000_0000, 4'd0);
    send_request(CMD_ERASE,      32'hFFFF_FFFF, 32'h0000_0000, 4'd0);
    send_request(CMD_LOOKUP,     32'hFFFF_FFFF, 32'h0000_0000, 4'd0);

    // Random phases, each under its own capacity and one of three idle mixes
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(cap_plan[p]);
      if (p < 3) begin
        send_idle_pct = 31;
        recv_idle_pct = 76;
      end else if (p < 6) begin
        send_idle_pct = 76;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      refresh_pool(6);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long reply stall while requests keep coming, and one full pause
        if (n == PHASE_ITEMS / 2 && (p == 1 || p == 4 || p == 6)) hold_asked++;
        if (n == PHASE_ITEMS / 2 && p == 7) drain_replies();
        send_random_request();
      end
    end

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Summary: %0d requests under %0d capacity writes; %0d replies checked, %0d ok, %0d inserts refused as full",
             requests_sent, cap_writes, table_shadow.replies_checked, table_shadow.hits,
             table_shadow.full_refusals);
    $display("  per command: ins %0d upd %0d ups %0d era %0d look %0d rd %0d spare %0d; errors %0d",
             cmd_counts[0], cmd_counts[1], cmd_counts[2], cmd_counts[3], cmd_counts[4],
             cmd_counts[5], cmd_counts[6] + cmd_counts[7], table_shadow.failures());
    if (table_shadow.failures() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/kvt_pkg.sv
rtl/kvt_ifs.sv
rtl/kvt_store.sv
rtl/kvt_seq.sv
rtl/key_value_table.sv
rtl/kvt_checker.sv
tb/key_value_table_tb.sv
